/* src/frck_pkg.sv */
// frck_pkg: shared types, codes and the crc-8 step for the frame receive checker
// no dependencies; used by all checker modules and the bench

package frck_pkg;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_POLY      = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_OWN_TYPE  = 1'b1;

  localparam logic [7:0] POLY_RESET      = 8'h07;
  localparam logic [3:0] OWN_TYPE_RESET  = 4'h0;
  localparam logic [3:0] ACC_SEQ_RESET   = 4'hf;
  localparam logic [7:0] CRC_TOP_BIT     = 8'h80;

  typedef enum logic [1:0] {
    VERDICT_ACCEPT   = 2'd0,
    VERDICT_DROP     = 2'd1,
    VERDICT_NACK_CRC = 2'd2,
    VERDICT_NACK_SEQ = 2'd3
  } verdict_t;

  // one finished frame waiting for its verdict
  typedef struct packed {
    logic [7:0] crc;
    logic [3:0] fseq;
    logic [3:0] ftype;
    logic [7:0] rcrc;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

  // msb-first crc-8 over one byte, unrolled
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data,
                                             input logic [7:0] poly);
    logic [7:0] v;
    v = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if ((v & CRC_TOP_BIT) != 8'h00) begin
        v = {v[6:0], 1'b0} ^ poly;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

/* src/frck_if.sv */
// frck_in_if / frck_out_if: valid-ready channels for received words and verdicts
// depends on nothing; field widths follow the checker's word layout

interface frck_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       first_byte;
  logic       last_byte;
  logic       empty_frame;
  logic [3:0] frame_seq;
  logic [3:0] frame_type;
  logic [7:0] received_crc;

  modport source(output valid, output payload_byte, output first_byte, output last_byte,
                 output empty_frame, output frame_seq, output frame_type,
                 output received_crc, input ready);
  modport sink(input valid, input payload_byte, input first_byte, input last_byte,
               input empty_frame, input frame_seq, input frame_type,
               input received_crc, output ready);
endinterface

interface frck_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic [3:0] nack_seq;
  logic [7:0] computed_crc;

  modport source(output valid, output verdict, output nack_seq, output computed_crc,
                 input ready);
  modport sink(input valid, input verdict, input nack_seq, input computed_crc,
               output ready);
endinterface

/* src/frck_front.sv */
// frck_front: takes received words, keeps the running crc and queues finished frames
// depends on frck_pkg and frck_in_if

module frck_front (
  input  logic                                clk,
  input  logic                                rst_n,
  frck_in_if.sink                             in_if,
  input  logic                                cfg_we,
  input  logic [frck_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [frck_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                q_full,
  output frck_pkg::q_push_t                   q_push
);

  logic [7:0] crc_r;
  logic [7:0] crc_nxt;
  logic [7:0] poly_r;
  logic [7:0] crc_base;
  logic [7:0] crc_new;
  logic       accept;

  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && in_if.ready;

  always_comb begin
    crc_base = in_if.first_byte ? 8'h00 : crc_r;
    crc_new  = in_if.empty_frame ? crc_base
                                 : frck_pkg::crc8_update(crc_base, in_if.payload_byte, poly_r);
    crc_nxt  = crc_r;
    if (accept) begin
      crc_nxt = in_if.last_byte ? 8'h00 : crc_new;
    end
  end

  always_comb begin
    q_push.valid       = accept && in_if.last_byte;
    q_push.entry.crc   = crc_new;
    q_push.entry.fseq  = in_if.frame_seq;
    q_push.entry.ftype = in_if.frame_type;
    q_push.entry.rcrc  = in_if.received_crc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= 8'h00;
      poly_r <= frck_pkg::POLY_RESET;
    end else begin
      crc_r <= crc_nxt;
      if (cfg_we && cfg_index == frck_pkg::CFG_IDX_POLY) begin
        poly_r <= cfg_wdata[7:0];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_crc_cleared_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_if.last_byte |=> crc_r == 8'h00)
    else $error("running crc not cleared after last word");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push.valid)
    else $error("frame queued while queue full");
`endif

endmodule

/* src/frck_queue.sv */
// frck_queue: small fifo of finished frames between front and back
// depends on frck_pkg

module frck_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  frck_pkg::q_push_t push,
  input  logic              pop,
  output logic              full,
  output frck_pkg::q_head_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  frck_pkg::q_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               do_pop;

  assign full       = cnt_r == CNT_W'(DEPTH);
  assign head.valid = cnt_r != '0;
  assign head.entry = mem_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push.valid && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !push.valid) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
`endif

endmodule

/* src/frck_back.sv */
// frck_back: gives the verdict for each queued frame and holds the sequence state
// depends on frck_pkg and frck_out_if

module frck_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [frck_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [frck_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  frck_pkg::q_head_t                   head,
  output logic                                pop,
  frck_out_if.source                          out_if
);

  logic [3:0]         own_type_r;
  logic [3:0]         acc_seq_r;
  logic [3:0]         acc_seq_nxt;
  logic [3:0]         tx_seq_r;
  logic [3:0]         tx_seq_nxt;
  logic               out_valid_r;
  logic [1:0]         verdict_r;
  logic [3:0]         nack_seq_r;
  logic [7:0]         crc_out_r;
  frck_pkg::verdict_t verdict;
  logic [3:0]         nack_seq;

  assign pop = head.valid && (!out_valid_r || out_if.ready);

  always_comb begin
    verdict     = frck_pkg::VERDICT_ACCEPT;
    nack_seq    = 4'h0;
    acc_seq_nxt = acc_seq_r;
    tx_seq_nxt  = tx_seq_r;
    priority if (head.entry.fseq == acc_seq_r || head.entry.ftype == own_type_r) begin
      verdict = frck_pkg::VERDICT_DROP;
    end else if (head.entry.crc != head.entry.rcrc) begin
      verdict    = frck_pkg::VERDICT_NACK_CRC;
      nack_seq   = tx_seq_r;
      tx_seq_nxt = tx_seq_r + 4'd1;
    end else if (head.entry.fseq != acc_seq_r + 4'd1) begin
      verdict    = frck_pkg::VERDICT_NACK_SEQ;
      nack_seq   = tx_seq_r;
      tx_seq_nxt = tx_seq_r + 4'd1;
    end else begin
      verdict     = frck_pkg::VERDICT_ACCEPT;
      acc_seq_nxt = head.entry.fseq;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      verdict_r  <= verdict;
      nack_seq_r <= nack_seq;
      crc_out_r  <= head.entry.crc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_type_r  <= frck_pkg::OWN_TYPE_RESET;
      acc_seq_r   <= frck_pkg::ACC_SEQ_RESET;
      tx_seq_r    <= 4'h0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == frck_pkg::CFG_IDX_OWN_TYPE) begin
        own_type_r <= cfg_wdata[3:0];
      end
      if (pop) begin
        acc_seq_r   <= acc_seq_nxt;
        tx_seq_r    <= tx_seq_nxt;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.verdict      = verdict_r;
  assign out_if.nack_seq     = nack_seq_r;
  assign out_if.computed_crc = crc_out_r;

`ifndef NO_ASSERTIONS
  a_nack_bumps_tx: assert property (@(posedge clk) disable iff (!rst_n)
    pop && (verdict == frck_pkg::VERDICT_NACK_CRC || verdict == frck_pkg::VERDICT_NACK_SEQ)
    |=> tx_seq_r == $past(tx_seq_r) + 4'd1)
    else $error("transmit sequence not advanced on nack");

  a_accept_sets_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop && verdict == frck_pkg::VERDICT_ACCEPT |=> acc_seq_r == $past(head.entry.fseq))
    else $error("last accepted sequence not updated");
`endif

endmodule

/* src/frame_receive_checker_crc8_seq4_unit.sv */
// frame_receive_checker_crc8_seq4_unit: top level of the stop-and-wait frame receive checker
// depends on frck_pkg, frck_if, frck_front, frck_queue and frck_back
//
// Takes one received word per cycle while in_if.ready is high; a word that does not end a
// frame causes no output, the last word of a frame yields one verdict (accept, drop, nack
// bad crc, nack bad sequence) with the nack sequence and the computed crc. The front updates
// the crc in one combinational step per word and queues each finished frame in a queue of
// QUEUE_DEPTH entries; the back pops one frame per cycle into an output register while that
// register is empty or being taken, and the verdict is offered on out_if from that register
// and taken at an edge when the output side is ready. in_if.ready drops only when the
// queue is full. Configuration (index 0 polynomial, index 1 own frame type) must be written
// through cfg_we while the block is idle; the block itself does not enforce this.

module frame_receive_checker_crc8_seq4_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  frck_in_if.sink                             in_if,
  frck_out_if.source                          out_if,
  input  logic                                cfg_we,
  input  logic [frck_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [frck_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  frck_pkg::q_push_t q_push;
  frck_pkg::q_head_t q_head;
  logic              q_full;
  logic              q_pop;

  frck_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push)
  );

  frck_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .pop   (q_pop),
    .full  (q_full),
    .head  (q_head)
  );

  frck_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .head      (q_head),
    .pop       (q_pop),
    .out_if    (out_if)
  );

endmodule

/* tb/tb_frame_receive_checker_crc8_seq4_unit.sv */
// tb_frame_receive_checker_crc8_seq4_unit: self-checking bench for the frame receive checker
// drives directed and random frames with bursty input and stalling output, predicts verdicts
// depends on frck_pkg, frck_if and frame_receive_checker_crc8_seq4_unit

module tb_frame_receive_checker_crc8_seq4_unit;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       empty;
    logic [3:0] seq;
    logic [3:0] ftype;
    logic [7:0] rcrc;
  } rx_word_t;

  typedef struct {
    frck_pkg::verdict_t verdict;
    logic [3:0]         nack_seq;
    logic [7:0]         crc;
  } verdict_rec_t;

  typedef enum {RX_FREE, RX_COIN, RX_SPARSE, RX_CHOKED} rx_pace_t;

  localparam int CRC_GOOD = -1;
  localparam int CRC_BAD  = -2;
  localparam int PHASES = 7;
  localparam int WORDS_PER_PHASE = 250;

  class verdict_board;
    logic [7:0]   poly;
    logic [3:0]   own_type;
    logic [7:0]   run_crc;
    logic [3:0]   acc_seq;
    logic [3:0]   tx_seq;
    verdict_rec_t verdicts_due[$];
    int           errors;

    function new();
      poly = frck_pkg::POLY_RESET;
      own_type = frck_pkg::OWN_TYPE_RESET;
      run_crc = 8'h00;
      acc_seq = frck_pkg::ACC_SEQ_RESET;
      tx_seq = 4'h0;
      errors = 0;
    endfunction

    function logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] r;
      r = crc ^ data;
      repeat (8) r = r[7] ? ((r << 1) ^ poly) : (r << 1);
      return r;
    endfunction

    function logic [7:0] crc_after(input rx_word_t w);
      logic [7:0] c;
      c = w.first ? 8'h00 : run_crc;
      if (!w.empty) c = crc_byte(c, w.data);
      return c;
    endfunction

    function void set_reg(input logic [frck_pkg::CFG_INDEX_W-1:0] idx,
                          input logic [frck_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        frck_pkg::CFG_IDX_POLY: poly = val;
        frck_pkg::CFG_IDX_OWN_TYPE: own_type = val[3:0];
        default: ;
      endcase
    endfunction

    function void note_word(input rx_word_t w);
      logic [7:0]   c;
      verdict_rec_t r;
      c = crc_after(w);
      if (!w.last) begin
        run_crc = c;
        return;
      end
      r.crc = c;
      r.nack_seq = 4'h0;
      if (w.seq == acc_seq || w.ftype == own_type) begin
        r.verdict = frck_pkg::VERDICT_DROP;
      end else if (c != w.rcrc) begin
        r.verdict = frck_pkg::VERDICT_NACK_CRC;
        r.nack_seq = tx_seq;
        tx_seq = tx_seq + 4'd1;
      end else if (w.seq != acc_seq + 4'd1) begin
        r.verdict = frck_pkg::VERDICT_NACK_SEQ;
        r.nack_seq = tx_seq;
        tx_seq = tx_seq + 4'd1;
      end else begin
        r.verdict = frck_pkg::VERDICT_ACCEPT;
        acc_seq = w.seq;
      end
      run_crc = 8'h00;
      verdicts_due.push_back(r);
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction

    task report(input string what, input logic [7:0] got, input logic [7:0] want);
      errors++;
      $display("mismatch on %s: got %0h, expected %0h", what, got, want);
    endtask

    task check_verdict(input logic [1:0] v, input logic [3:0] ns, input logic [7:0] c);
      verdict_rec_t r;
      if (verdicts_due.size() == 0) begin
        report("verdict with none due", v, 8'h00);
        return;
      end
      r = verdicts_due.pop_front();
      if (v !== r.verdict) report("verdict", v, r.verdict);
      if (ns !== r.nack_seq) report("nack_seq", ns, r.nack_seq);
      if (c !== r.crc) report("computed_crc", c, r.crc);
    endtask
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_we;
  logic [frck_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [frck_pkg::CFG_DATA_W-1:0]  cfg_wdata;

  frck_in_if  in_ch();
  frck_out_if out_ch();

  frame_receive_checker_crc8_seq4_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_ch),
    .out_if(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  verdict_board board = new();
  int           burst_left = 0;
  int           words_sent = 0;
  rx_pace_t     rx_pace = RX_FREE;
  int           rx_pace_left = 0;
  int           rx_cnt = 0;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // output side stall pattern, changes pace every so often
  always @(negedge clk) begin
    if (rx_pace_left == 0) begin
      rx_pace = rx_pace_t'($urandom_range(0, 3));
      rx_pace_left = $urandom_range(20, 200);
    end
    rx_pace_left--;
    rx_cnt++;
    case (rx_pace)
      RX_FREE: out_ch.ready <= 1'b1;
      RX_COIN: out_ch.ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ch.ready <= (rx_cnt % 4 == 0);
      default: out_ch.ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      board.check_verdict(out_ch.verdict, out_ch.nack_seq, out_ch.computed_crc);
    end
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  task automatic send_word(input rx_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    @(negedge clk);
    in_ch.payload_byte <= w.data;
    in_ch.first_byte <= w.first;
    in_ch.last_byte <= w.last;
    in_ch.empty_frame <= w.empty;
    in_ch.frame_seq <= w.seq;
    in_ch.frame_type <= w.ftype;
    in_ch.received_crc <= w.rcrc;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    board.note_word(w);
    words_sent++;
  endtask

  task automatic send_item(input logic [7:0] data, input logic first, input logic last,
                           input logic empty, input logic [3:0] seq, input logic [3:0] ftype,
                           input int crc_sel);
    rx_word_t w;
    w.data = data;
    w.first = first;
    w.last = last;
    w.empty = empty;
    w.seq = seq;
    w.ftype = ftype;
    w.rcrc = 8'h00;
    if (crc_sel == CRC_GOOD) w.rcrc = board.crc_after(w);
    else if (crc_sel == CRC_BAD) w.rcrc = board.crc_after(w) ^ 8'($urandom_range(1, 255));
    else w.rcrc = crc_sel[7:0];
    send_word(w);
  endtask

  task automatic send_rand_frame();
    int         len;
    int         pick;
    int         crc_sel;
    logic [3:0] seq;
    logic [3:0] ftype;
    bit         skip_first;
    bit         broken;
    rx_word_t   w;
    if ($urandom_range(0, 5) == 0) begin
      w.data = 8'($urandom);
      w.first = 1'($urandom);
      w.last = 1'($urandom);
      w.empty = 1'($urandom);
      w.seq = 4'($urandom);
      w.ftype = 4'($urandom);
      w.rcrc = 8'($urandom);
      send_word(w);
      return;
    end
    if ($urandom_range(0, 9) == 0) len = 0;
    else if ($urandom_range(0, 7) == 0) len = $urandom_range(5, 12);
    else len = $urandom_range(1, 4);
    pick = $urandom_range(0, 9);
    if (pick < 6) seq = board.acc_seq + 4'd1;
    else if (pick == 6) seq = board.acc_seq;
    else seq = 4'($urandom);
    if ($urandom_range(0, 7) == 0) begin
      ftype = board.own_type;
    end else begin
      ftype = 4'($urandom);
      if (ftype == board.own_type) ftype = ftype + 4'd1;
    end
    if ($urandom_range(0, 5) != 0) crc_sel = CRC_GOOD;
    else if ($urandom_range(0, 1) == 0) crc_sel = CRC_BAD;
    else crc_sel = $urandom_range(0, 255);
    skip_first = ($urandom_range(0, 11) == 0);
    broken = ($urandom_range(0, 15) == 0);
    if (len == 0) begin
      send_item(8'($urandom), 1'b1, 1'b1, 1'b1, seq, ftype, crc_sel);
    end else begin
      for (int i = 0; i < len; i++) begin
        send_item(8'($urandom), (i == 0) && !skip_first, (i == len - 1) && !broken,
                  (i > 0) && ($urandom_range(0, 9) == 0), seq, ftype, crc_sel);
      end
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [frck_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [frck_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_phase(input logic [7:0] poly, input logic [7:0] own);
    drain();
    repeat (6) @(posedge clk);
    cfg_write(frck_pkg::CFG_IDX_POLY, poly);
    cfg_write(frck_pkg::CFG_IDX_OWN_TYPE, own);
  endtask

  initial begin
    logic [7:0] poly_set [PHASES];
    logic [7:0] own_val;
    int         target;
    poly_set = '{8'h00, 8'hFF, 8'h31, 8'h07, 8'h1D, 8'h9B, 8'h00};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.payload_byte = 8'h00;
    in_ch.first_byte = 1'b0;
    in_ch.last_byte = 1'b0;
    in_ch.empty_frame = 1'b0;
    in_ch.frame_seq = 4'h0;
    in_ch.frame_type = 4'h0;
    in_ch.received_crc = 8'h00;
    out_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed frames under reset settings
    send_item(8'h00, 1'b1, 1'b1, 1'b0, 4'h0, 4'h1, CRC_GOOD);
    send_item(8'hFF, 1'b1, 1'b1, 1'b0, 4'h1, 4'hF, CRC_GOOD);
    send_item(8'hA5, 1'b1, 1'b1, 1'b1, 4'h2, 4'h2, CRC_GOOD);
    send_item(8'h3C, 1'b1, 1'b1, 1'b0, 4'h2, 4'h3, CRC_GOOD);
    send_item(8'h11, 1'b1, 1'b1, 1'b0, 4'h3, 4'h0, CRC_GOOD);
    send_item(8'h80, 1'b1, 1'b1, 1'b0, 4'h3, 4'h4, CRC_BAD);
    send_item(8'h01, 1'b1, 1'b1, 1'b0, 4'h9, 4'h5, CRC_GOOD);
    // multi-word frame with an empty word inside
    send_item(8'h80, 1'b1, 1'b0, 1'b0, 4'h3, 4'h6, CRC_GOOD);
    send_item(8'h55, 1'b0, 1'b0, 1'b1, 4'h3, 4'h6, CRC_GOOD);
    send_item(8'hFF, 1'b0, 1'b1, 1'b0, 4'h3, 4'h6, CRC_GOOD);
    // no first mark right after a verdict
    send_item(8'h12, 1'b0, 1'b0, 1'b0, 4'h4, 4'h7, CRC_GOOD);
    send_item(8'h34, 1'b0, 1'b1, 1'b0, 4'h4, 4'h7, CRC_GOOD);
    // first mark repeated mid frame restarts the crc
    send_item(8'h99, 1'b1, 1'b0, 1'b0, 4'h5, 4'h8, CRC_GOOD);
    send_item(8'h77, 1'b1, 1'b0, 1'b0, 4'h5, 4'h8, CRC_GOOD);
    send_item(8'h00, 1'b0, 1'b1, 1'b0, 4'h5, 4'h8, CRC_GOOD);
    // received crc extremes
    send_item(8'h00, 1'b1, 1'b1, 1'b1, 4'h6, 4'h9, 8'h00);
    send_item(8'h00, 1'b1, 1'b1, 1'b0, 4'h7, 4'hA, 8'hFF);
    // three-word frame that starts with a first mark and ends with a last mark
    send_item(8'h5A, 1'b1, 1'b0, 1'b0, 4'h7, 4'hB, CRC_GOOD);
    send_item(8'hA5, 1'b0, 1'b0, 1'b0, 4'h7, 4'hB, CRC_GOOD);
    send_item(8'h0F, 1'b0, 1'b1, 1'b0, 4'h7, 4'hB, CRC_GOOD);

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) own_val = 8'hFF;
      else if (p == 1) own_val = 8'hA0;
      else own_val = 8'($urandom);
      if (p == PHASES - 1) poly_set[p] = 8'($urandom);
      program_phase(poly_set[p], own_val);
      target = words_sent + WORDS_PER_PHASE;
      while (words_sent < target) send_rand_frame();
    end

    drain();
    repeat (12) @(posedge clk);
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* frame_receive_checker_crc8_seq4_unit.f */
src/frck_pkg.sv
src/frck_if.sv
src/frck_front.sv
src/frck_queue.sv
src/frck_back.sv
src/frame_receive_checker_crc8_seq4_unit.sv
tb/tb_frame_receive_checker_crc8_seq4_unit.sv
